>>> rtl/gfht_pkg.sv
package gfht_pkg;

  // Controller ID codes.
  localparam logic [7:0] ID_ANALOG = 8'h73;
  localparam logic [7:0] ID_DIGITAL = 8'h41;
  localparam logic [7:0] ID_CONFIG = 8'h20;
  localparam logic [7:0] ID_FAULT = 8'hFF;

  // Neutral values and register defaults.
  localparam logic [7:0] STICK_CENTER = 8'd128;
  localparam logic [7:0] BUTTONS_IDLE = 8'hFF;
  localparam logic [7:0] LIMIT_RESET = 8'd10;
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // One received poll frame, in receive order.
  typedef struct packed {
    logic [7:0] left_y;
    logic [7:0] left_x;
    logic [7:0] right_y;
    logic [7:0] right_x;
    logic [7:0] buttons_high;
    logic [7:0] buttons_low;
    logic [7:0] header_byte;
    logic [7:0] mode_id;
  } poll_frame_t;

  // The part of a frame that reaches the output and is kept between frames.
  typedef struct packed {
    logic [7:0] left_y;
    logic [7:0] left_x;
    logic [7:0] right_y;
    logic [7:0] right_x;
    logic [7:0] buttons_high;
    logic [7:0] buttons_low;
  } pad_bytes_t;

  // One qualified result item.
  typedef struct packed {
    logic        disconnected;
    logic        data_held;
    logic        reinit_request;
    logic [7:0]  out_right_y;
    logic [7:0]  out_right_x;
    logic [7:0]  out_left_y;
    logic [7:0]  out_left_x;
    logic [15:0] pressed_mask;
  } pad_result_t;

  // State update produced by the qualifier.
  typedef struct packed {
    logic       empty;
    pad_bytes_t stored_next;
    logic [7:0] missed_count_next;
  } qual_update_t;

  localparam pad_bytes_t NEUTRAL_BYTES = '{
    left_y: STICK_CENTER, left_x: STICK_CENTER,
    right_y: STICK_CENTER, right_x: STICK_CENTER,
    buttons_high: BUTTONS_IDLE, buttons_low: BUTTONS_IDLE
  };

endpackage

>>> rtl/gfht_qualify.sv
module gfht_qualify (
  input  gfht_pkg::poll_frame_t  frame,
  input  gfht_pkg::pad_bytes_t   stored,
  input  logic [7:0]             missed_count,
  input  logic [7:0]             limit,
  output gfht_pkg::pad_result_t  result,
  output gfht_pkg::qual_update_t update
);

  logic                 is_reinit;
  logic                 is_empty;
  logic [7:0]           count_inc;
  logic [7:0]           count_cap;
  logic                 over_limit;
  gfht_pkg::pad_bytes_t used;

  // Classify the frame: a reinit ID is never zero, so it can never be empty.
  assign is_reinit = (frame.mode_id == gfht_pkg::ID_DIGITAL) ||
                     (frame.mode_id == gfht_pkg::ID_CONFIG) ||
                     (frame.mode_id == gfht_pkg::ID_FAULT);
  assign is_empty  = (frame == '0);

  // Saturating missed-frame count and the limit test.
  assign count_inc  = (missed_count == gfht_pkg::COUNT_MAX) ? gfht_pkg::COUNT_MAX
                                                            : missed_count + 8'd1;
  assign count_cap  = (limit == gfht_pkg::COUNT_MAX) ? gfht_pkg::COUNT_MAX
                                                     : limit + 8'd1;
  assign over_limit = count_inc > limit;

  // Choose the bytes that are output and kept.
  always_comb begin
    priority if (is_reinit) begin
      used = gfht_pkg::NEUTRAL_BYTES;
    end else if (is_empty && over_limit) begin
      used = gfht_pkg::NEUTRAL_BYTES;
    end else if (is_empty) begin
      used = stored;
    end else begin
      used = '{
        left_y: frame.left_y, left_x: frame.left_x,
        right_y: frame.right_y, right_x: frame.right_x,
        buttons_high: frame.buttons_high, buttons_low: frame.buttons_low
      };
    end
  end

  // Result item: buttons inverted so that a set bit means pressed.
  assign result.pressed_mask   = ~{used.buttons_high, used.buttons_low};
  assign result.out_left_x     = used.left_x;
  assign result.out_left_y     = used.left_y;
  assign result.out_right_x    = used.right_x;
  assign result.out_right_y    = used.right_y;
  assign result.reinit_request = is_reinit;
  assign result.data_held      = is_empty;
  assign result.disconnected   = is_empty && over_limit;

  // State update.
  assign update.empty             = is_empty;
  assign update.stored_next       = used;
  assign update.missed_count_next = !is_empty  ? 8'd0 :
                                    over_limit ? count_cap : count_inc;

endmodule

>>> rtl/gamepad_frame_hold_timeout_core.sv
// Path: input register, then result register; an item waits in the input register
// while the result register holds an item that m_axis_tready has not drained.
// Throughput: one item per cycle while m_axis_tready drains; the two registers are
// separated by one pass of byte compares and an 8-bit counter update.
// Reset (synchronous, active high): both stages empty, missed count zero, limit 10,
// stored frame buttons released and sticks centered.
module gamepad_frame_hold_timeout_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata,       // missed_frame_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode_id, header_byte, buttons_low, buttons_high, right_x, right_y, left_x, left_y
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pressed_mask, out_left_x, out_left_y, out_right_x, out_right_y
  output logic [47:0] m_axis_tdata,
  // reinit_request, data_held, disconnected
  output logic [2:0]  m_axis_tuser
);

  logic                    in_valid;
  gfht_pkg::poll_frame_t   in_frame;
  logic                    out_valid;
  gfht_pkg::pad_result_t   out_result;
  gfht_pkg::pad_bytes_t    stored;
  logic [7:0]              missed_count;
  logic [7:0]              limit;
  logic                    advance;
  gfht_pkg::pad_result_t   result;
  gfht_pkg::qual_update_t  update;

  // The result register can load when it is empty or being drained.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= gfht_pkg::LIMIT_RESET;
    end else if (cfg_wen) begin
      limit <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_frame <= gfht_pkg::poll_frame_t'(s_axis_tdata);
    end
  end

  gfht_qualify u_qualify (
    .frame        (in_frame),
    .stored       (stored),
    .missed_count (missed_count),
    .limit        (limit),
    .result       (result),
    .update       (update)
  );

  // Frame history and missed-frame count advance with each item.
  always_ff @(posedge clk) begin
    if (rst) begin
      stored       <= gfht_pkg::NEUTRAL_BYTES;
      missed_count <= 8'd0;
    end else if (advance) begin
      stored       <= update.stored_next;
      missed_count <= update.missed_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_result.out_right_y, out_result.out_right_x,
                          out_result.out_left_y, out_result.out_left_x,
                          out_result.pressed_mask};
  assign m_axis_tuser  = {out_result.disconnected, out_result.data_held,
                          out_result.reinit_request};

  // A disconnected result is always a held one.
  a_disc_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_result.disconnected || out_result.data_held))
    else $error("disconnected result without data_held");

  // A reinit frame is never treated as empty.
  a_reinit_not_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_result.reinit_request && out_result.data_held))
    else $error("reinit result marked as held");

  // An empty frame always leaves a nonzero missed count.
  a_count_rises: assert property (@(posedge clk) disable iff (rst)
    (advance && update.empty) |=> (missed_count != 8'd0))
    else $error("missed count zero after empty frame");

  // A non-empty frame clears the count.
  a_count_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && !update.empty) |=> (missed_count == 8'd0))
    else $error("missed count not cleared after good frame");

  // Disconnected results carry centered sticks; left_x and right_y are checked.
  a_disc_center: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.disconnected) |->
      (out_result.out_left_x == gfht_pkg::STICK_CENTER &&
       out_result.out_right_y == gfht_pkg::STICK_CENTER))
    else $error("disconnected result without centered sticks");

endmodule

>>> verif/gamepad_frame_hold_timeout_core_tb.sv
module gamepad_frame_hold_timeout_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // mode_id, header_byte, buttons_low, buttons_high, right_x, right_y, left_x, left_y
  logic [63:0] s_axis_tdata = 64'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // pressed_mask, out_left_x, out_left_y, out_right_x, out_right_y
  logic [47:0] m_axis_tdata;
  // reinit_request, data_held, disconnected
  logic [2:0]  m_axis_tuser;

  gamepad_frame_hold_timeout_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Frames waiting to be sent and qualified frames waiting to come out.
  gfht_pkg::poll_frame_t frames_to_send[$];
  gfht_pkg::pad_result_t results_due[$];

  // Shadow of the block state: kept frame, missed-frame count and limit.
  gfht_pkg::pad_bytes_t kept_bytes = gfht_pkg::NEUTRAL_BYTES;
  logic [7:0] missed_frames = 8'd0;
  logic [7:0] frame_limit = gfht_pkg::LIMIT_RESET;

  int  fail_count = 0;
  int  send_wait = 0;
  int  recv_wait = 0;
  bit  in_idle_on = 1'b1;
  bit  out_idle_on = 1'b1;

  // Qualify one frame and advance the shadow state.
  function automatic gfht_pkg::pad_result_t qualify_frame(input gfht_pkg::poll_frame_t f);
    gfht_pkg::pad_bytes_t  used;
    gfht_pkg::pad_result_t r;
    logic        empty_frame;
    logic [8:0]  cnt;
    used.buttons_low  = f.buttons_low;
    used.buttons_high = f.buttons_high;
    used.right_x      = f.right_x;
    used.right_y      = f.right_y;
    used.left_x       = f.left_x;
    used.left_y       = f.left_y;
    empty_frame = (f == '0);
    r = '0;
    // A reinitializing ID replaces the frame by the neutral one.
    if (f.mode_id == gfht_pkg::ID_DIGITAL || f.mode_id == gfht_pkg::ID_CONFIG ||
        f.mode_id == gfht_pkg::ID_FAULT) begin
      r.reinit_request = 1'b1;
      used = gfht_pkg::NEUTRAL_BYTES;
      empty_frame = 1'b0;
    end
    // An empty frame repeats the kept one until the count passes the limit.
    if (empty_frame) begin
      r.data_held = 1'b1;
      cnt = {1'b0, missed_frames} + 9'd1;
      if (cnt > 9'd255) cnt = 9'd255;
      if (cnt > {1'b0, frame_limit}) begin
        cnt = {1'b0, frame_limit} + 9'd1;
        if (cnt > 9'd255) cnt = 9'd255;
        kept_bytes = gfht_pkg::NEUTRAL_BYTES;
        r.disconnected = 1'b1;
      end
      missed_frames = cnt[7:0];
      used = kept_bytes;
    end else begin
      missed_frames = 8'd0;
    end
    kept_bytes = used;
    r.pressed_mask = ~{used.buttons_high, used.buttons_low};
    r.out_left_x   = used.left_x;
    r.out_left_y   = used.left_y;
    r.out_right_x  = used.right_x;
    r.out_right_y  = used.right_y;
    return r;
  endfunction

  function automatic gfht_pkg::poll_frame_t make_frame(input logic [7:0] id,
                                                       input logic [7:0] hdr,
                                                       input logic [7:0] bl,
                                                       input logic [7:0] bh,
                                                       input logic [7:0] rx,
                                                       input logic [7:0] ry,
                                                       input logic [7:0] lx,
                                                       input logic [7:0] ly);
    return {ly, lx, ry, rx, bh, bl, hdr, id};
  endfunction

  function automatic int draw_wait(input bit on);
    return on ? int'($urandom_range(0, 8)) : 0;
  endfunction

  task automatic queue_empty_run(input int n);
    for (int i = 0; i < n; i++) frames_to_send.push_back('0);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Wait until every queued frame was sent and every result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (frames_to_send.size() != 0 || s_axis_tvalid || results_due.size() != 0);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Frame driver: after each accepted item, the next one is held back for a random wait when input idles are on.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_wait = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        results_due.push_back(qualify_frame(gfht_pkg::poll_frame_t'(s_axis_tdata)));
        send_wait = draw_wait(in_idle_on);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_wait != 0) begin
          send_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (frames_to_send.size() != 0) begin
          s_axis_tdata  <= frames_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each item with the oldest expectation, then may stall.
  always @(posedge clk) begin
    gfht_pkg::pad_result_t got;
    gfht_pkg::pad_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = gfht_pkg::pad_result_t'({m_axis_tuser, m_axis_tdata});
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result item %h", $time, got);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("pressed_mask", want.pressed_mask, got.pressed_mask);
          check_field("out_left_x", 16'(want.out_left_x), 16'(got.out_left_x));
          check_field("out_left_y", 16'(want.out_left_y), 16'(got.out_left_y));
          check_field("out_right_x", 16'(want.out_right_x), 16'(got.out_right_x));
          check_field("out_right_y", 16'(want.out_right_y), 16'(got.out_right_y));
          check_field("reinit_request", 16'(want.reinit_request),
                      16'(got.reinit_request));
          check_field("data_held", 16'(want.data_held), 16'(got.data_held));
          check_field("disconnected", 16'(want.disconnected), 16'(got.disconnected));
        end
        recv_wait = draw_wait(out_idle_on);
      end
      if (recv_wait != 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus: a directed opening, then phases with different limits.
  initial begin
    int          phase_limits[10];
    int          lim;
    int          phase_items;
    int          kind;
    int          n;
    gfht_pkg::poll_frame_t f;
    phase_limits = '{1, 254, 2, 3, 10, 0, 0, 1, 254, 0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Empty frame right after reset repeats the reset frame.
    queue_empty_run(1);
    // Field extremes on an analog frame.
    frames_to_send.push_back(make_frame(gfht_pkg::ID_ANALOG, 8'h5A, 8'h00, 8'h00,
                                        8'h00, 8'h00, 8'h00, 8'h00));
    frames_to_send.push_back(make_frame(gfht_pkg::ID_ANALOG, 8'h5A, 8'hFF, 8'hFF,
                                        8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // Each reinitializing ID.
    f = {$urandom, $urandom};
    f.mode_id = gfht_pkg::ID_DIGITAL;
    frames_to_send.push_back(f);
    frames_to_send.push_back(make_frame(gfht_pkg::ID_CONFIG, 8'h00, 8'h00, 8'h00,
                                        8'h00, 8'h00, 8'h00, 8'h00));
    frames_to_send.push_back(make_frame(gfht_pkg::ID_FAULT, 8'hFF, 8'hFF, 8'hFF,
                                        8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // A distinct frame to be held, then enough empty frames to pass the limit.
    frames_to_send.push_back(make_frame(gfht_pkg::ID_ANALOG, 8'h00, 8'hA5, 8'h3C,
                                        8'h01, 8'h80, 8'hFE, 8'h7F));
    queue_empty_run(12);
    // Frames with a single nonzero byte are not empty.
    frames_to_send.push_back(make_frame(8'h00, 8'h5A, 8'h00, 8'h00,
                                        8'h00, 8'h00, 8'h00, 8'h00));
    frames_to_send.push_back(make_frame(8'h00, 8'h00, 8'h00, 8'h00,
                                        8'h00, 8'h00, 8'h00, 8'h01));
    frames_to_send.push_back(make_frame(8'h01, 8'h00, 8'h00, 8'h00,
                                        8'h00, 8'h00, 8'h00, 8'h00));
    // Leave a count behind so the next, lower limit is already exceeded.
    queue_empty_run(4);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      lim = phase_limits[p];
      if (lim == 0) lim = (p == 6) ? int'($urandom_range(1, 254)) : int'($urandom_range(1, 20));
      in_idle_on  = (p != 2) && ($urandom_range(0, 3) != 0);
      out_idle_on = (p != 2) && (p != 5) && ($urandom_range(0, 3) != 0);

      // Limit write while the block is idle.
      @(posedge clk);
      cfg_wen   <= 1'b1;
      cfg_wdata <= 8'(lim);
      frame_limit = 8'(lim);
      @(posedge clk);
      cfg_wen <= 1'b0;

      queue_empty_run($urandom_range(0, 3));
      // Long empty run that drives the count to its ceiling.
      if (p == 1) queue_empty_run(258);

      phase_items = 0;
      while (phase_items < 130) begin
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
          f = {$urandom, $urandom};
          f.mode_id = gfht_pkg::ID_ANALOG;
          if ($urandom_range(0, 7) != 0) f.header_byte = 8'h5A;
          frames_to_send.push_back(f);
          n = 1;
        end else if (kind < 62) begin
          n = $urandom_range(1, (lim + 3 > 40) ? 40 : lim + 3);
          queue_empty_run(n);
        end else if (kind < 74) begin
          f = {$urandom, $urandom};
          case ($urandom_range(0, 2))
            0: f.mode_id = gfht_pkg::ID_DIGITAL;
            1: f.mode_id = gfht_pkg::ID_CONFIG;
            default: f.mode_id = gfht_pkg::ID_FAULT;
          endcase
          frames_to_send.push_back(f);
          n = 1;
        end else if (kind < 87) begin
          // Nearly empty: one nonzero byte anywhere.
          f = '0;
          f[$urandom_range(0, 7) * 8 +: 8] = 8'($urandom_range(1, 255));
          frames_to_send.push_back(f);
          n = 1;
        end else begin
          frames_to_send.push_back({$urandom, $urandom});
          n = 1;
        end
        phase_items += n;
      end
      // Hold off sending until every result of this phase has come back.
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("gamepad_frame_hold_timeout_core_tb: PASS");
    end else begin
      $display("gamepad_frame_hold_timeout_core_tb: FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("gamepad_frame_hold_timeout_core_tb: FAIL");
    $finish;
  end

endmodule
